@@ rtl/core/rtzls_pkg.sv @@
// Shared types, register codes and constants of the radar target zone lock selector.
package rtzls_pkg;

  typedef struct packed {
    logic               slot_used;
    logic signed [15:0] slot_lateral;
    logic signed [15:0] slot_depth;
    logic signed [15:0] slot_speed;
    logic [7:0]         slot_target_id;
    logic               last_slot;
    logic [31:0]        now_ms;
  } slot_beat_t;

  typedef struct packed {
    logic               tracking;
    logic [2:0]         selected_slot;
    logic [15:0]        sample_distance;
    logic signed [15:0] report_lateral;
    logic signed [15:0] report_depth;
    logic               any_visible;
    logic               any_in_zone;
    logic               is_stationary;
    logic               enter_event;
    logic               exit_event;
  } result_beat_t;

  typedef enum logic [2:0] {
    REG_VALID_RANGE_MIN      = 3'd0,
    REG_VALID_RANGE_MAX      = 3'd1,
    REG_ZONE_RANGE_MIN       = 3'd2,
    REG_ZONE_RANGE_MAX       = 3'd3,
    REG_ZONE_SIDE_LIMIT      = 3'd4,
    REG_PICK_MOTION_LIMIT    = 3'd5,
    REG_STILL_SPEED_LIMIT    = 3'd6,
    REG_STILL_VELOCITY_LIMIT = 3'd7
  } cfg_reg_t;

  // Shared multiplier ops in issue order: per-slot pass, then stationary test.
  typedef enum logic [2:0] {
    MUL_XX   = 3'd0,
    MUL_YY   = 3'd1,
    MUL_VMIN = 3'd2,
    MUL_VMAX = 3'd3,
    MUL_ZMIN = 3'd4,
    MUL_ZMAX = 3'd5,
    MUL_DEL  = 3'd6,
    MUL_VDT  = 3'd7
  } mul_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_FIN,
    S_SQRT,
    S_STAT,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic    load;
    logic    mul_go;
    mul_op_t mul_op;
    logic    update;
    logic    sqrt_go;
    logic    emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic take;
    logic last;
    logic cand;
    logic sqrt_done;
    logic out_free;
  } dp_status_t;

  localparam logic [15:0] RST_VALID_RANGE_MIN      = 16'd100;
  localparam logic [15:0] RST_VALID_RANGE_MAX      = 16'd6000;
  localparam logic [15:0] RST_ZONE_RANGE_MIN       = 16'd800;
  localparam logic [15:0] RST_ZONE_RANGE_MAX       = 16'd1200;
  localparam logic [15:0] RST_ZONE_SIDE_LIMIT      = 16'd150;
  localparam logic [14:0] RST_PICK_MOTION_LIMIT    = 15'd60;
  localparam logic [14:0] RST_STILL_SPEED_LIMIT    = 15'd80;
  localparam logic [15:0] RST_STILL_VELOCITY_LIMIT = 16'd100;

  // mm/s against mm per ms
  localparam logic [31:0] STILL_SCALE = 32'd1000;

  function automatic logic [15:0] abs16(input logic [15:0] v);
    logic [15:0] n;
    n = ~v + 16'd1;
    return v[15] ? n : v;
  endfunction

endpackage

@@ rtl/core/rtzls_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
module rtzls_isqrt import rtzls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);

  logic [31:0] rem;
  logic [31:0] res;
  logic [31:0] bitv;
  logic [3:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign root  = res[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 4'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitv <= 32'h4000_0000;
      cnt  <= '0;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[31:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + 4'd1;
    end
  end

endmodule

@@ rtl/core/rtzls_ctrl.sv @@
// Sequencer for slot checks, distance root, stationary test and result hand-off.
module rtzls_ctrl import rtzls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       slot_valid,
  output logic       slot_stall,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] MUL_DRAIN  = 3'd6;
  localparam logic [2:0] STAT_DRAIN = 3'd2;

  ctrl_state_t state, state_next;
  logic [2:0]  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next  = state;
    step_next   = step;
    cmd         = '0;
    cmd.mul_op  = MUL_XX;
    slot_stall  = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (slot_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (!st.take) begin
          state_next = st.last ? S_FIN : S_IDLE;
        end else if (step != MUL_DRAIN) begin
          // issue squares of x, y and the four range limits
          cmd.mul_go = 1'b1;
          cmd.mul_op = mul_op_t'(step);
          step_next  = step + 3'd1;
        end else begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = st.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (st.cand) begin
          cmd.sqrt_go = 1'b1;
          state_next  = S_SQRT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SQRT: begin
        if (st.sqrt_done) begin
          step_next  = '0;
          state_next = S_STAT;
        end
      end
      S_STAT: begin
        if (step == 3'd0) begin
          cmd.mul_go = 1'b1;
          cmd.mul_op = MUL_DEL;
        end else if (step == 3'd1) begin
          cmd.mul_go = 1'b1;
          cmd.mul_op = MUL_VDT;
        end
        step_next = step + 3'd1;
        if (step == STAT_DRAIN) state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold until the result register is free
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/rtzls_dp.sv @@
// Datapath: config registers, slot tests, candidate and lock state, result register.
module rtzls_dp import rtzls_pkg::*; #(
  parameter int MAX_SLOTS = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  slot_beat_t   slot,
  output result_beat_t result,
  output logic         result_valid,
  input  logic         result_stall,
  input  ctrl_cmd_t    cmd,
  output dp_status_t   st
);

  localparam int CW = $clog2(MAX_SLOTS + 1);

  // configuration
  logic [15:0] valid_range_min, valid_range_max, zone_range_min, zone_range_max;
  logic [15:0] zone_side_limit, still_velocity_limit;
  logic [14:0] pick_motion_limit, still_speed_limit;

  // latched slot and derived values
  slot_beat_t  item;
  logic [15:0] abs_x, abs_y, abs_speed;

  // shared multiplier
  logic [15:0] mul_a;
  logic [31:0] mul_b;
  logic [47:0] prod;
  logic        prod_valid;
  mul_op_t     op_q;
  logic [31:0] r2;
  logic        ge_vmin, le_vmax, ge_zmin, le_zmax;
  logic [47:0] lhs;
  logic        dist_still;

  // frame state
  logic [CW-1:0] slot_cnt;
  logic [3:0]    cnt_ext;
  logic          f_vis, f_inz, f_lockseen, f_cand;
  logic signed [15:0] first_x, first_y;
  logic [2:0]    best_slot;
  logic signed [15:0] best_x, best_y, best_speed;
  logic [31:0]   best_r2;
  logic          best_slow;
  logic [7:0]    best_id;

  // lock state
  logic        lock_active;
  logic [7:0]  locked_id;
  logic [15:0] prev_distance;
  logic [31:0] prev_time;
  logic        prev_valid;

  // root
  logic        sqrt_done;
  logic [15:0] root;

  logic        present, zone, slow, better;
  logic [15:0] delta;
  logic [31:0] dt;
  logic        speed_still, dist_gate;

  rtzls_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_go),
    .radicand (best_r2),
    .done     (sqrt_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_range_min      <= RST_VALID_RANGE_MIN;
      valid_range_max      <= RST_VALID_RANGE_MAX;
      zone_range_min       <= RST_ZONE_RANGE_MIN;
      zone_range_max       <= RST_ZONE_RANGE_MAX;
      zone_side_limit      <= RST_ZONE_SIDE_LIMIT;
      pick_motion_limit    <= RST_PICK_MOTION_LIMIT;
      still_speed_limit    <= RST_STILL_SPEED_LIMIT;
      still_velocity_limit <= RST_STILL_VELOCITY_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VALID_RANGE_MIN:      valid_range_min      <= cfg_data;
        REG_VALID_RANGE_MAX:      valid_range_max      <= cfg_data;
        REG_ZONE_RANGE_MIN:       zone_range_min       <= cfg_data;
        REG_ZONE_RANGE_MAX:       zone_range_max       <= cfg_data;
        REG_ZONE_SIDE_LIMIT:      zone_side_limit      <= cfg_data;
        REG_PICK_MOTION_LIMIT:    pick_motion_limit    <= cfg_data[14:0];
        REG_STILL_SPEED_LIMIT:    still_speed_limit    <= cfg_data[14:0];
        REG_STILL_VELOCITY_LIMIT: still_velocity_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= slot;
  end

  assign abs_x     = abs16(item.slot_lateral);
  assign abs_y     = abs16(item.slot_depth);
  assign abs_speed = abs16(item.slot_speed);

  assign delta = (root > prev_distance) ? (root - prev_distance) : (prev_distance - root);
  assign dt    = item.now_ms - prev_time;

  always_comb begin
    mul_a = abs_x;
    mul_b = {16'd0, abs_x};
    unique case (cmd.mul_op)
      MUL_XX:   begin mul_a = abs_x;                mul_b = {16'd0, abs_x};           end
      MUL_YY:   begin mul_a = abs_y;                mul_b = {16'd0, abs_y};           end
      MUL_VMIN: begin mul_a = valid_range_min;      mul_b = {16'd0, valid_range_min}; end
      MUL_VMAX: begin mul_a = valid_range_max;      mul_b = {16'd0, valid_range_max}; end
      MUL_ZMIN: begin mul_a = zone_range_min;       mul_b = {16'd0, zone_range_min};  end
      MUL_ZMAX: begin mul_a = zone_range_max;       mul_b = {16'd0, zone_range_max};  end
      MUL_DEL:  begin mul_a = delta;                mul_b = STILL_SCALE;              end
      MUL_VDT:  begin mul_a = still_velocity_limit; mul_b = dt;                       end
      default: ;
    endcase
  end

  // product register, consumed in the cycle after issue
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod <= 48'(mul_a) * 48'(mul_b);
      op_q <= cmd.mul_op;
    end
    if (prod_valid) begin
      unique case (op_q)
        MUL_XX:   r2         <= prod[31:0];
        MUL_YY:   r2         <= r2 + prod[31:0];
        MUL_VMIN: ge_vmin    <= (r2 >= prod[31:0]);
        MUL_VMAX: le_vmax    <= (r2 <= prod[31:0]);
        MUL_ZMIN: ge_zmin    <= (r2 >= prod[31:0]);
        MUL_ZMAX: le_zmax    <= (r2 <= prod[31:0]);
        MUL_DEL:  lhs        <= prod;
        MUL_VDT:  dist_still <= (lhs < prod);
        default: ;
      endcase
    end
  end

  assign present = ge_vmin && le_vmax;
  assign zone    = ge_zmin && le_zmax && (abs_x <= zone_side_limit);
  assign slow    = abs_speed < {1'b0, pick_motion_limit};
  assign cnt_ext = 4'(slot_cnt);

  always_comb begin
    if (!f_cand)                better = 1'b1;
    else if (slow != best_slow) better = slow;
    else                        better = (r2 < best_r2);
  end

  // frame flags and slot counter
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      slot_cnt   <= '0;
      f_vis      <= 1'b0;
      f_inz      <= 1'b0;
      f_lockseen <= 1'b0;
      f_cand     <= 1'b0;
    end else if (cmd.update) begin
      slot_cnt <= slot_cnt + CW'(1);
      if (present) begin
        f_vis <= 1'b1;
        if (zone) f_inz <= 1'b1;
      end
      if (lock_active) begin
        if (!f_lockseen && item.slot_target_id == locked_id) begin
          f_lockseen <= 1'b1;
          if (present && zone) f_cand <= 1'b1;
        end
      end else if (present && zone && better) begin
        f_cand <= 1'b1;
      end
    end
  end

  // frame payload
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (present && !f_vis) begin
        first_x <= item.slot_lateral;
        first_y <= item.slot_depth;
      end
      if ((lock_active && !f_lockseen && item.slot_target_id == locked_id &&
           present && zone) ||
          (!lock_active && present && zone && better)) begin
        best_slot  <= cnt_ext[2:0];
        best_x     <= item.slot_lateral;
        best_y     <= item.slot_depth;
        best_speed <= item.slot_speed;
        best_r2    <= r2;
        best_slow  <= slow;
        best_id    <= item.slot_target_id;
      end
    end
  end

  assign speed_still = abs16(best_speed) <= {1'b0, still_speed_limit};
  assign dist_gate   = prev_valid && (prev_time != 32'd0) && (dt != 32'd0) && dist_still;

  // lock state
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_active   <= 1'b0;
      locked_id     <= '0;
      prev_distance <= '0;
      prev_time     <= '0;
      prev_valid    <= 1'b0;
    end else if (cmd.emit) begin
      if (f_cand) begin
        lock_active   <= 1'b1;
        locked_id     <= best_id;
        prev_distance <= root;
        prev_time     <= item.now_ms;
        prev_valid    <= 1'b1;
      end else begin
        lock_active <= 1'b0;
        locked_id   <= '0;
        prev_valid  <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.any_visible <= f_vis;
      if (f_cand) begin
        result.tracking        <= 1'b1;
        result.selected_slot   <= best_slot;
        result.sample_distance <= root;
        result.report_lateral  <= best_x;
        result.report_depth    <= best_y;
        result.any_in_zone     <= 1'b1;
        result.is_stationary   <= speed_still || dist_gate;
        result.enter_event     <= !lock_active;
        result.exit_event      <= 1'b0;
      end else begin
        result.tracking        <= 1'b0;
        result.selected_slot   <= '0;
        result.sample_distance <= '0;
        result.report_lateral  <= f_vis ? first_x : 16'sd0;
        result.report_depth    <= f_vis ? first_y : 16'sd0;
        result.any_in_zone     <= f_inz;
        result.is_stationary   <= 1'b0;
        result.enter_event     <= 1'b0;
        result.exit_event      <= lock_active;
      end
    end
  end

  assign st.take      = item.slot_used && (slot_cnt < CW'(MAX_SLOTS));
  assign st.last      = item.last_slot;
  assign st.cand      = f_cand;
  assign st.sqrt_done = sqrt_done;
  assign st.out_free  = !result_valid || !result_stall;

endmodule

@@ rtl/core/radar_target_zone_lock_selector_core.sv @@
// Top level of the radar target zone lock selector.
// Takes one radar slot per beat; a beat with last_slot set closes the frame and yields one
// result beat. A used slot goes through accept, six passes through the shared 16x32
// multiplier for x^2, y^2 and the four squared range limits, drain and update; an unused
// or surplus slot only through accept and the take check. Closing a frame with a selected
// target adds a decision, the 16-step iterative square root of the distance and its done
// flag, two multiplier passes and a drain for the stationary test, and the result load;
// without a target the decision leads straight to the load; the load waits for a free
// output register. The finished result sits in an output register, so the next slot is
// taken while it waits. Config writes go straight to the registers and belong in idle time.
module radar_target_zone_lock_selector_core import rtzls_pkg::*; #(
  parameter int MAX_SLOTS = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         slot_valid,
  output logic         slot_stall,
  input  slot_beat_t   slot,
  output logic         result_valid,
  input  logic         result_stall,
  output result_beat_t result
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  rtzls_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .slot_valid (slot_valid),
    .slot_stall (slot_stall),
    .st         (st),
    .cmd        (cmd)
  );

  rtzls_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .slot         (slot),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .st           (st)
  );

endmodule
